// ===== src/hbud_pkg.sv =====
// ----------------------------------------------------------------------------
// hbud_pkg
// Shared types and constants of the byte unstuffing deframer.
// ----------------------------------------------------------------------------
package hbud_pkg;

  // Largest packet the store holds; the count fields of the command word are sized to it.
  localparam int unsigned MAX_PACKET_BYTES = 64;
  localparam int unsigned PKT_CNT_W        = $clog2(MAX_PACKET_BYTES + 1);

  localparam logic [7:0] FLAG_BYTE  = 8'h7E;
  localparam logic [7:0] ESC_BYTE   = 8'h7D;
  localparam logic [7:0] ESC_FOR_7D = 8'h5D;
  localparam logic [7:0] ESC_FOR_7E = 8'h5E;

  // Input opcodes.
  localparam logic OP_RECEIVE = 1'b0;
  localparam logic OP_CLEAR   = 1'b1;

  // Result kinds. A queued command of kind KIND_PACKET means "replay the store".
  typedef enum logic [1:0] {
    KIND_PACKET    = 2'd0,
    KIND_SKIPPED   = 2'd1,
    KIND_BAD_ESC   = 2'd2,
    KIND_OVERFLOW  = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e                  kind;
    logic [7:0]             data;
    logic [PKT_CNT_W-1:0]   count;
  } cmd_t;

  // Replay engine states.
  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_ISSUE = 3'b010,
    ST_EMIT  = 3'b100
  } back_state_e;

endpackage

// ===== src/hbud_if.sv =====
// ----------------------------------------------------------------------------
// hbud_in_if / hbud_out_if
// Valid/ready channels for raw line bytes and for deframed result items.
// ----------------------------------------------------------------------------
interface hbud_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] data_byte;

  modport source (output valid, output opcode, output data_byte, input ready);
  modport sink   (input valid, input opcode, input data_byte, output ready);
endinterface

interface hbud_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] payload_byte;
  logic       last;

  modport source (output valid, output kind, output payload_byte, output last,
                  input ready);
  modport sink   (input valid, input kind, input payload_byte, input last,
                  output ready);
endinterface

// ===== src/hbud_ram.sv =====
// ----------------------------------------------------------------------------
// hbud_ram
// Generic single write port RAM with one registered, enabled read port.
// ----------------------------------------------------------------------------
module hbud_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/hbud_front.sv =====
// ----------------------------------------------------------------------------
// hbud_front
// Flag and escape parser. Writes payload bytes into the packet store and
// queues one command per result or per packet to replay.
// ----------------------------------------------------------------------------
module hbud_front #(
  parameter int unsigned MaxPacketBytes = hbud_pkg::MAX_PACKET_BYTES
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  hbud_in_if.sink                           in_i,
  output logic                              push_o,
  output hbud_pkg::cmd_t                    cmd_o,
  input  logic                              q_ready_i,
  input  logic                              replay_done_i,
  output logic                              we_o,
  output logic [$clog2(MaxPacketBytes)-1:0] waddr_o,
  output logic [7:0]                        wdata_o
);
  import hbud_pkg::*;

  localparam int unsigned CntW  = $clog2(MaxPacketBytes + 1);
  localparam int unsigned AddrW = $clog2(MaxPacketBytes);

  logic            started_q, started_d;
  logic            esc_q, esc_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            replay_pend_q, replay_pend_d;
  logic            accept;
  logic            store_req;
  logic [7:0]      store_val;

  // The store is frozen while a packet is being replayed.
  assign in_i.ready = q_ready_i && !replay_pend_q;
  assign accept     = in_i.valid && in_i.ready;
  assign waddr_o    = cnt_q[AddrW-1:0];

  always_comb begin
    started_d     = started_q;
    esc_d         = esc_q;
    cnt_d         = cnt_q;
    replay_pend_d = replay_pend_q;
    push_o        = 1'b0;
    cmd_o         = '{kind: KIND_SKIPPED, data: in_i.data_byte, count: '0};
    store_req     = 1'b0;
    store_val     = in_i.data_byte;
    we_o          = 1'b0;
    wdata_o       = in_i.data_byte;

    if (replay_done_i) begin
      replay_pend_d = 1'b0;
    end

    if (accept) begin
      if (in_i.opcode == OP_CLEAR) begin
        started_d = 1'b0;
        esc_d     = 1'b0;
        cnt_d     = '0;
      end else if (!started_q) begin
        if (in_i.data_byte == FLAG_BYTE) begin
          started_d = 1'b1;
        end else begin
          push_o = 1'b1;
        end
      end else if (esc_q) begin
        esc_d = 1'b0;
        if (in_i.data_byte == ESC_FOR_7D) begin
          store_req = 1'b1;
          store_val = ESC_BYTE;
        end else if (in_i.data_byte == ESC_FOR_7E) begin
          store_req = 1'b1;
          store_val = FLAG_BYTE;
        end else begin
          started_d = 1'b0;
          cnt_d     = '0;
          push_o    = 1'b1;
          cmd_o     = '{kind: KIND_BAD_ESC, data: 8'h00, count: '0};
        end
      end else if (in_i.data_byte == FLAG_BYTE) begin
        cnt_d = '0;
        if (cnt_q != '0) begin
          push_o        = 1'b1;
          cmd_o         = '{kind: KIND_PACKET, data: 8'h00, count: PKT_CNT_W'(cnt_q)};
          replay_pend_d = 1'b1;
        end
      end else if (in_i.data_byte == ESC_BYTE) begin
        esc_d = 1'b1;
      end else begin
        store_req = 1'b1;
      end
    end

    if (store_req) begin
      if (cnt_q >= CntW'(MaxPacketBytes)) begin
        started_d = 1'b0;
        esc_d     = 1'b0;
        cnt_d     = '0;
        push_o    = 1'b1;
        cmd_o     = '{kind: KIND_OVERFLOW, data: 8'h00, count: '0};
      end else begin
        we_o    = 1'b1;
        wdata_o = store_val;
        cnt_d   = cnt_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q     <= 1'b0;
      esc_q         <= 1'b0;
      cnt_q         <= '0;
      replay_pend_q <= 1'b0;
    end else begin
      started_q     <= started_d;
      esc_q         <= esc_d;
      cnt_q         <= cnt_d;
      replay_pend_q <= replay_pend_d;
    end
  end

endmodule

// ===== src/hbud_queue.sv =====
// ----------------------------------------------------------------------------
// hbud_queue
// Two-entry command queue between the parser and the replay engine.
// ----------------------------------------------------------------------------
module hbud_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  hbud_pkg::cmd_t cmd_i,
  output logic           ready_o,
  output logic           valid_o,
  output hbud_pkg::cmd_t cmd_o,
  input  logic           pop_i
);
  import hbud_pkg::*;

  cmd_t       entry_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] fill_q;

  assign ready_o = (fill_q != 2'd2);
  assign valid_o = (fill_q != 2'd0);
  assign cmd_o   = entry_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      fill_q <= 2'd0;
    end else begin
      if (push_i) begin
        wptr_q <= !wptr_q;
      end
      if (pop_i) begin
        rptr_q <= !rptr_q;
      end
      fill_q <= fill_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

endmodule

// ===== src/hbud_back.sv =====
// ----------------------------------------------------------------------------
// hbud_back
// Replay engine. Turns queued commands into result items, reading the
// packet store one byte at a time, and holds the output register.
// ----------------------------------------------------------------------------
module hbud_back #(
  parameter int unsigned MaxPacketBytes = hbud_pkg::MAX_PACKET_BYTES
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              q_valid_i,
  input  hbud_pkg::cmd_t                    cmd_i,
  output logic                              pop_o,
  output logic                              re_o,
  output logic [$clog2(MaxPacketBytes)-1:0] raddr_o,
  input  logic [7:0]                        rdata_i,
  output logic                              replay_done_o,
  hbud_out_if.source                        out_o
);
  import hbud_pkg::*;

  localparam int unsigned CntW  = $clog2(MaxPacketBytes + 1);
  localparam int unsigned AddrW = $clog2(MaxPacketBytes);

  back_state_e     state_q, state_d;
  logic [CntW-1:0] idx_q, idx_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            out_valid_q, out_valid_d;
  logic [1:0]      kind_q;
  logic [7:0]      byte_q;
  logic            last_q;
  logic            slot_free;
  logic            load;
  logic [1:0]      ld_kind;
  logic [7:0]      ld_byte;
  logic            ld_last;
  logic            final_byte;

  assign slot_free  = !out_valid_q || out_o.ready;
  assign raddr_o    = idx_q[AddrW-1:0];
  assign final_byte = ((idx_q + CntW'(1)) == cnt_q);

  always_comb begin
    state_d       = state_q;
    idx_d         = idx_q;
    cnt_d         = cnt_q;
    pop_o         = 1'b0;
    re_o          = 1'b0;
    replay_done_o = 1'b0;
    load          = 1'b0;
    ld_kind       = cmd_i.kind;
    ld_byte       = cmd_i.data;
    ld_last       = 1'b1;

    unique case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          if (cmd_i.kind == KIND_PACKET) begin
            pop_o   = 1'b1;
            cnt_d   = CntW'(cmd_i.count);
            idx_d   = '0;
            state_d = ST_ISSUE;
          end else if (slot_free) begin
            pop_o = 1'b1;
            load  = 1'b1;
          end
        end
      end
      ST_ISSUE: begin
        re_o    = 1'b1;
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (slot_free) begin
          load    = 1'b1;
          ld_kind = KIND_PACKET;
          ld_byte = rdata_i;
          ld_last = final_byte;
          if (final_byte) begin
            replay_done_o = 1'b1;
            state_d       = ST_IDLE;
          end else begin
            idx_d   = idx_q + CntW'(1);
            state_d = ST_ISSUE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q <= ld_kind;
      byte_q <= ld_byte;
      last_q <= ld_last;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.kind         = kind_q;
  assign out_o.payload_byte = byte_q;
  assign out_o.last         = last_q;

endmodule

// ===== src/hbud_byte_unstuff_deframer_core.sv =====
// ----------------------------------------------------------------------------
// hdlc_byte_unstuff_deframer_core
// Byte unstuffing HDLC deframer: flag hunting, escape removal, packet buffer.
//
// A skipped byte or an error result passes from the parser through the command
// queue into the output register. Input items are taken one per cycle
// while no packet is being replayed and the output keeps up. A closing flag
// of a non-empty packet starts a replay of the packet store, which reads each
// stored byte from the RAM and then loads it into the output register, and
// input is held off until the last byte has been loaded.
// Reset clears the parser, the queue and the output register; the packet
// store itself is not cleared, since it is only read below the fill count.
// ----------------------------------------------------------------------------
module hdlc_byte_unstuff_deframer_core #(
  parameter int unsigned MaxPacketBytes = hbud_pkg::MAX_PACKET_BYTES
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  hbud_in_if.sink     in_i,
  hbud_out_if.source  out_o
);
  import hbud_pkg::*;

  localparam int unsigned AddrW = $clog2(MaxPacketBytes);

  // Front side: parser outputs toward the queue and the store.
  logic             push;
  cmd_t             push_cmd;
  logic             q_ready;
  logic             st_we;
  logic [AddrW-1:0] st_waddr;
  logic [7:0]       st_wdata;

  // Back side: queue head and store read port.
  logic             q_valid;
  cmd_t             head_cmd;
  logic             pop;
  logic             st_re;
  logic [AddrW-1:0] st_raddr;
  logic [7:0]       st_rdata;
  logic             replay_done;

  // The parser owns flag/escape state and the fill count. It writes the
  // store and queues a command for every result or packet it produces.
  hbud_front #(
    .MaxPacketBytes(MaxPacketBytes)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_i          (in_i),
    .push_o        (push),
    .cmd_o         (push_cmd),
    .q_ready_i     (q_ready),
    .replay_done_i (replay_done),
    .we_o          (st_we),
    .waddr_o       (st_waddr),
    .wdata_o       (st_wdata)
  );

  // The queue lets the parser keep taking bytes while results wait on a
  // stalled output.
  hbud_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .ready_o (q_ready),
    .valid_o (q_valid),
    .cmd_o   (head_cmd),
    .pop_i   (pop)
  );

  // Packet store. It is written only by the parser and read only by the
  // replay engine; the parser stays stalled while a replay is pending.
  hbud_ram #(
    .Width(8),
    .Depth(MaxPacketBytes)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (st_wdata),
    .re_i    (st_re),
    .raddr_i (st_raddr),
    .rdata_o (st_rdata)
  );

  // The replay engine drives the output register.
  hbud_back #(
    .MaxPacketBytes(MaxPacketBytes)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .cmd_i         (head_cmd),
    .pop_o         (pop),
    .re_o          (st_re),
    .raddr_o       (st_raddr),
    .rdata_i       (st_rdata),
    .replay_done_o (replay_done),
    .out_o         (out_o)
  );

endmodule

// ===== dv/tb_hdlc_byte_unstuff_deframer_core.sv =====
// ----------------------------------------------------------------------------
// tb_hdlc_byte_unstuff_deframer_core
// Self-checking bench for the HDLC byte unstuffing deframer. Raw line items
// are pushed through the input channel with random gaps, and a cycle-free
// model of the flag hunter, the escape removal and the packet store predicts
// every result item, which is then matched in order at the output channel.
// ----------------------------------------------------------------------------
module tb_hdlc_byte_unstuff_deframer_core;
  timeunit 1ns;
  timeprecision 1ps;

  import hbud_pkg::*;

  localparam int unsigned ItemTarget = 470;  // stimulus length, in input items
  localparam int unsigned QuietLimit = 5000; // cycles with no item moving
  localparam int unsigned TailCycles = 20;   // settle time once all results came
  localparam int unsigned HoldOffLen = 600;  // long output stall, in cycles

  // One raw line item. A set drain_first makes the driver wait until every
  // predicted result has been taken before it offers this item.
  typedef struct {
    logic       opcode;
    logic [7:0] data;
    bit         drain_first;
  } line_item_t;

  typedef struct {
    kind_e      kind;
    logic [7:0] payload;
    logic       last;
  } result_t;

  logic clk_i;
  logic rst_ni;

  hbud_in_if  line_if ();
  hbud_out_if result_if ();

  hdlc_byte_unstuff_deframer_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (line_if),
    .out_o  (result_if)
  );

  line_item_t  line_items[$];       // items not yet offered to the block
  result_t     expected_results[$]; // predicted results, oldest first
  int unsigned mismatches;
  int unsigned items_taken;         // input items accepted so far
  int unsigned idle_cycles;
  logic        steady;              // no gaps on either side while set

  // Private copy of the deframer state.
  bit          in_frame;
  bit          escaped;
  logic [7:0]  frame_buf[MAX_PACKET_BYTES];
  int unsigned frame_len;

  // Two windows in which both sides run back to back without idling.
  assign steady = (items_taken >= 120 && items_taken < 200) ||
                  (items_taken >= 400 && items_taken < 440);

  // --------------------------------------------------------------------------
  // Clock and reset
  // --------------------------------------------------------------------------
  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------
  function automatic void push_result(kind_e k, logic [7:0] b, logic l);
    result_t r;
    r.kind    = k;
    r.payload = b;
    r.last    = l;
    expected_results.insert(expected_results.size(), r);
  endfunction

  // Loses the packet in progress and goes back to hunting for a flag.
  function automatic void drop_frame();
    in_frame  = 1'b0;
    escaped   = 1'b0;
    frame_len = 0;
  endfunction

  // Stores one unstuffed byte; a full store turns it into an overflow error.
  function automatic void keep_byte(logic [7:0] b);
    if (frame_len >= MAX_PACKET_BYTES) begin
      drop_frame();
      push_result(KIND_OVERFLOW, 8'h00, 1'b1);
    end else begin
      frame_buf[frame_len] = b;
      frame_len++;
    end
  endfunction

  // Works out the results that one accepted line item causes.
  function automatic void deframe_line_item(logic op, logic [7:0] b);
    if (op == OP_CLEAR) begin
      drop_frame();
    end else if (!in_frame) begin
      // Before the first flag every byte is handed on as skipped.
      if (b == FLAG_BYTE) in_frame = 1'b1;
      else push_result(KIND_SKIPPED, b, 1'b1);
    end else if (escaped) begin
      escaped = 1'b0;
      if (b == ESC_FOR_7D) keep_byte(ESC_BYTE);
      else if (b == ESC_FOR_7E) keep_byte(FLAG_BYTE);
      else begin
        // Any other byte after an escape, a flag too, kills the packet.
        drop_frame();
        push_result(KIND_BAD_ESC, 8'h00, 1'b1);
      end
    end else if (b == FLAG_BYTE) begin
      // Closing flag: replay the store; an empty packet gives nothing.
      for (int unsigned i = 0; i < frame_len; i++) begin
        push_result(KIND_PACKET, frame_buf[i], (i + 1 == frame_len));
      end
      frame_len = 0;
    end else if (b == ESC_BYTE) begin
      escaped = 1'b1;
    end else begin
      keep_byte(b);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic void add_item(logic op, logic [7:0] b, bit drain);
    line_item_t it;
    it.opcode      = op;
    it.data        = b;
    it.drain_first = drain;
    line_items.insert(line_items.size(), it);
  endfunction

  // Adds one packet byte in its stuffed form on the line.
  function automatic void add_payload(logic [7:0] b);
    if (b == FLAG_BYTE) begin
      add_item(OP_RECEIVE, ESC_BYTE, 1'b0);
      add_item(OP_RECEIVE, ESC_FOR_7E, 1'b0);
    end else if (b == ESC_BYTE) begin
      add_item(OP_RECEIVE, ESC_BYTE, 1'b0);
      add_item(OP_RECEIVE, ESC_FOR_7D, 1'b0);
    end else begin
      add_item(OP_RECEIVE, b, 1'b0);
    end
  endfunction

  // Random byte with the flag, the escape and the escape codes made common.
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 19))
      0: return FLAG_BYTE;
      1: return ESC_BYTE;
      2: return ESC_FOR_7D;
      3: return ESC_FOR_7E;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic int unsigned draw_wait();
    return steady ? 0 : $urandom_range(0, 9);
  endfunction

  // --------------------------------------------------------------------------
  // Driver: offers the queued line items, predicting each one as it is taken.
  // --------------------------------------------------------------------------
  int unsigned send_wait;
  line_item_t  next_item;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_if.valid     <= 1'b0;
      line_if.opcode    <= OP_RECEIVE;
      line_if.data_byte <= 8'h00;
      items_taken       <= 0;
      send_wait         = 0;
      drop_frame();
    end else begin
      if (line_if.valid && line_if.ready) begin
        deframe_line_item(line_if.opcode, line_if.data_byte);
        items_taken <= items_taken + 1;
      end
      // A new item is only set up once the current one has gone.
      if (!line_if.valid || line_if.ready) begin
        if (send_wait != 0) begin
          send_wait--;
          line_if.valid <= 1'b0;
        end else if (line_items.size() == 0 ||
                     (line_items[0].drain_first && expected_results.size() != 0)) begin
          line_if.valid <= 1'b0;
        end else begin
          next_item = line_items.pop_front();
          line_if.valid     <= 1'b1;
          line_if.opcode    <= next_item.opcode;
          line_if.data_byte <= next_item.data;
          send_wait = draw_wait();
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: checks each taken result against the oldest prediction and
  // throttles ready, with two long hold-offs below.
  // --------------------------------------------------------------------------
  int unsigned take_wait;
  int unsigned hold_left;
  bit          first_hold_done;
  bit          second_hold_done;
  result_t     want;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_if.ready  <= 1'b0;
      take_wait        = 0;
      hold_left        = 0;
      first_hold_done  = 1'b0;
      second_hold_done = 1'b0;
    end else begin
      if (result_if.valid && result_if.ready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result: kind %0d byte 0x%02h last %0b",
                 result_if.kind, result_if.payload_byte, result_if.last);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (result_if.kind !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, result_if.kind);
            mismatches++;
          end
          if (result_if.payload_byte !== want.payload) begin
            $error("payload_byte: expected 0x%02h, got 0x%02h",
                   want.payload, result_if.payload_byte);
            mismatches++;
          end
          if (result_if.last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, result_if.last);
            mismatches++;
          end
        end
        take_wait = draw_wait();
      end
      // The first hold-off lands inside the full-size packet, so the closing
      // flag starts a replay that cannot drain and the input gets stalled.
      if (!first_hold_done && items_taken >= 40) begin
        first_hold_done = 1'b1;
        hold_left       = HoldOffLen;
      end else if (!second_hold_done && items_taken >= 300) begin
        second_hold_done = 1'b1;
        hold_left        = HoldOffLen;
      end
      if (hold_left != 0) begin
        hold_left--;
        result_if.ready <= 1'b0;
      end else if (take_wait != 0) begin
        take_wait--;
        result_if.ready <= 1'b0;
      end else begin
        result_if.ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: a run in which nothing moves for too long is a hang.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((line_if.valid && line_if.ready) || (result_if.valid && result_if.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= QuietLimit) begin
        $display("tb_hdlc_byte_unstuff_deframer_core NOT OK");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of test
  // --------------------------------------------------------------------------
  int unsigned seg;
  int unsigned len;
  int unsigned pick;
  logic [7:0]  bad;

  initial begin
    // Directed part. Bytes before any flag, the escape among them, come out
    // as skipped bytes.
    add_item(OP_RECEIVE, 8'h00, 1'b0);
    add_item(OP_RECEIVE, 8'hFF, 1'b0);
    add_item(OP_RECEIVE, ESC_BYTE, 1'b0);
    // Opening flag followed by a repeated flag, which must stay silent.
    add_item(OP_RECEIVE, FLAG_BYTE, 1'b0);
    add_item(OP_RECEIVE, FLAG_BYTE, 1'b0);
    // Packet with both byte extremes and both escape sequences.
    add_item(OP_RECEIVE, 8'h00, 1'b0);
    add_item(OP_RECEIVE, 8'hFF, 1'b0);
    add_payload(ESC_BYTE);
    add_payload(FLAG_BYTE);
    add_item(OP_RECEIVE, FLAG_BYTE, 1'b0);
    // A flag right after an escape is a bad escape.
    add_item(OP_RECEIVE, ESC_BYTE, 1'b0);
    add_item(OP_RECEIVE, FLAG_BYTE, 1'b0);
    // Now hunting again: this byte is skipped, then a bad escape mid-packet.
    add_item(OP_RECEIVE, 8'h5A, 1'b0);
    add_item(OP_RECEIVE, FLAG_BYTE, 1'b0);
    add_item(OP_RECEIVE, 8'h22, 1'b0);
    add_item(OP_RECEIVE, ESC_BYTE, 1'b0);
    add_item(OP_RECEIVE, 8'h33, 1'b0);
    // A clear while hunting, and a clear that throws away a partial packet.
    add_item(OP_CLEAR, 8'hAA, 1'b0);
    add_item(OP_RECEIVE, 8'h44, 1'b0);
    add_item(OP_RECEIVE, FLAG_BYTE, 1'b0);
    add_item(OP_RECEIVE, 8'h55, 1'b0);
    add_item(OP_CLEAR, FLAG_BYTE, 1'b0);
    add_item(OP_RECEIVE, 8'h66, 1'b0);

    // A packet that fills the store exactly, then one byte too many. The
    // sender waits for the directed results to drain before the first flag.
    add_item(OP_RECEIVE, FLAG_BYTE, 1'b1);
    for (int i = 0; i < MAX_PACKET_BYTES; i++) add_payload(8'($urandom_range(0, 255)));
    add_item(OP_RECEIVE, FLAG_BYTE, 1'b0);
    for (int i = 0; i <= MAX_PACKET_BYTES; i++) add_payload(8'($urandom_range(0, 255)));
    add_item(OP_RECEIVE, FLAG_BYTE, 1'b0);

    // Random part: mostly well-formed packets of random content, the rest
    // broken packets and line noise with clears.
    while (line_items.size() < ItemTarget) begin
      seg = $urandom_range(0, 99);
      if (seg < 72) begin
        if ($urandom_range(0, 4) == 0) add_item(OP_RECEIVE, FLAG_BYTE, 1'b0);
        pick = $urandom_range(0, 99);
        if (pick < 80) len = $urandom_range(0, 10);
        else if (pick < 95) len = $urandom_range(11, 30);
        else if (pick < 98) len = $urandom_range(MAX_PACKET_BYTES - 4, MAX_PACKET_BYTES);
        else len = $urandom_range(MAX_PACKET_BYTES + 1, MAX_PACKET_BYTES + 4);
        for (int i = 0; i < len; i++) add_payload(pick_byte());
        add_item(OP_RECEIVE, FLAG_BYTE, 1'b0);
      end else if (seg < 86) begin
        // Packet cut short by an escape that is followed by a wrong byte.
        len = $urandom_range(0, 6);
        for (int i = 0; i < len; i++) add_payload(pick_byte());
        bad = 8'($urandom_range(0, 255));
        if (bad == ESC_FOR_7D || bad == ESC_FOR_7E) bad = FLAG_BYTE;
        add_item(OP_RECEIVE, ESC_BYTE, 1'b0);
        add_item(OP_RECEIVE, bad, 1'b0);
      end else begin
        len = $urandom_range(1, 6);
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(0, 4) == 0) add_item(OP_CLEAR, 8'($urandom_range(0, 255)), 1'b0);
          else add_item(OP_RECEIVE, pick_byte(), 1'b0);
        end
      end
    end
    // One more full drain pause in the middle of the random part.
    line_items[300].drain_first = 1'b1;

    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    while (line_items.size() != 0 || line_if.valid) @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("tb_hdlc_byte_unstuff_deframer_core OK");
    end else begin
      $display("tb_hdlc_byte_unstuff_deframer_core NOT OK");
    end
    $finish;
  end

endmodule
